FILE: rtl/bsm_pkg.sv
package bsm_pkg;

   // request codes on req_type
   localparam logic [1:0] REQ_STEP    = 2'd0;
   localparam logic [1:0] REQ_INVERT  = 2'd1;
   localparam logic [1:0] REQ_REVERSE = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_X_LEFT   = 3'd0;
   localparam logic [2:0] CSR_X_RIGHT  = 3'd1;
   localparam logic [2:0] CSR_Y_BOTTOM = 3'd2;
   localparam logic [2:0] CSR_Y_TOP    = 3'd3;
   localparam logic [2:0] CSR_SPEED    = 3'd4;

   localparam int SPRITE_SIZE = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_STEP,
      OP_INVERT,
      OP_REVERSE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  sprite;
      logic [14:0] rand_speed;
      logic        keep_x;
      logic        keep_y;
      logic [14:0] rand_x;
      logic [14:0] rand_y;
   } cmd_type;

   typedef struct packed {
      logic [11:0] x_left;
      logic [11:0] x_right;
      logic [11:0] y_bottom;
      logic [11:0] y_top;
      logic [3:0]  speed;
   } cfg_type;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [20:0] vel_x;
      logic [20:0] vel_y;
      logic        drawn_inv;
   } rec_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_ROOT,
      ST_SCALE,
      ST_PLACE_X,
      ST_PLACE_Y,
      ST_BOUNCE,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/bouncing_sprite_motion.sv
// Sprite motion engine: a table of NUM_SPRITES sprites with 16.16 positions and
// velocities. A step request moves one sprite and returns one beat with its
// new pixel position and, for a running sprite, its old one; invert-toggle and
// reverse requests, unknown codes and out-of-range sprites return nothing.
// Requests go into a four-entry queue and are executed one at a time by a
// sequencer over a sprite RAM with registered read. Toggle and reverse act as
// they leave the queue; a step of a running sprite goes through fetch, add,
// bounce and write back; a first step runs the bit-serial square root that
// sets |vy|, then scale and placement. A result waits in an output register,
// so requests keep queueing while it is stalled; execution pauses only when
// the result register is still occupied. Configuration writes are always ready
// and take effect at once; write them only while the block is idle.
module bouncing_sprite_motion #(
   parameter int NUM_SPRITES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [2:0]         req_sprite_index,
   input  logic [14:0]        req_rand_speed,
   input  logic               req_keep_x_sign,
   input  logic               req_keep_y_sign,
   input  logic [14:0]        req_rand_x,
   input  logic [14:0]        req_rand_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_out_sprite,
   output logic               rsp_erase_valid,
   output logic signed [13:0] rsp_erase_x,
   output logic signed [13:0] rsp_erase_y,
   output logic               rsp_erase_inverted,
   output logic signed [13:0] rsp_draw_x,
   output logic signed [13:0] rsp_draw_y,
   output logic               rsp_draw_inverted,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [11:0]        csr_wdata
);

   localparam int IDX_W = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;

   bsm_pkg::cfg_type  cfg_ff, cfg_in;
   bsm_pkg::cmd_type  push_cmd;
   bsm_pkg::cmd_type  head;
   bsm_pkg::rec_type  ram_wr_data;
   bsm_pkg::rec_type  ram_rd_data;
   logic              push;
   logic              pop;
   logic              q_full;
   logic              q_empty;
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [IDX_W-1:0]  ram_rd_addr;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            bsm_pkg::CSR_X_LEFT:   cfg_in.x_left   = csr_wdata;
            bsm_pkg::CSR_X_RIGHT:  cfg_in.x_right  = csr_wdata;
            bsm_pkg::CSR_Y_BOTTOM: cfg_in.y_bottom = csr_wdata;
            bsm_pkg::CSR_Y_TOP:    cfg_in.y_top    = csr_wdata;
            bsm_pkg::CSR_SPEED:    cfg_in.speed    = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_left   <= 12'd0;
         cfg_ff.x_right  <= 12'd640;
         cfg_ff.y_bottom <= 12'd0;
         cfg_ff.y_top    <= 12'd480;
         cfg_ff.speed    <= 4'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bsm_front #(
      .NUM_SPRITES (NUM_SPRITES)
   ) u_front (
      .req_valid        (req_valid),
      .req_type         (req_type),
      .req_sprite_index (req_sprite_index),
      .req_rand_speed   (req_rand_speed),
      .req_keep_x_sign  (req_keep_x_sign),
      .req_keep_y_sign  (req_keep_y_sign),
      .req_rand_x       (req_rand_x),
      .req_rand_y       (req_rand_y),
      .q_full           (q_full),
      .req_stall        (req_stall),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   bsm_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (head)
   );

   bsm_ram #(
      .WIDTH ($bits(bsm_pkg::rec_type)),
      .DEPTH (NUM_SPRITES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bsm_back #(
      .NUM_SPRITES (NUM_SPRITES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_empty            (q_empty),
      .head               (head),
      .pop                (pop),
      .ram_wr_en          (ram_wr_en),
      .ram_wr_addr        (ram_wr_addr),
      .ram_wr_data        (ram_wr_data),
      .ram_rd_addr        (ram_rd_addr),
      .ram_rd_data        (ram_rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_sprite     (rsp_out_sprite),
      .rsp_erase_valid    (rsp_erase_valid),
      .rsp_erase_x        (rsp_erase_x),
      .rsp_erase_y        (rsp_erase_y),
      .rsp_erase_inverted (rsp_erase_inverted),
      .rsp_draw_x         (rsp_draw_x),
      .rsp_draw_y         (rsp_draw_y),
      .rsp_draw_inverted  (rsp_draw_inverted)
   );

endmodule

FILE: rtl/bsm_ram.sv
module bsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  logic [WIDTH-1:0]        wr_data,
   input  logic [ADDR_W-1:0]       rd_addr,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: rtl/bsm_front.sv
module bsm_front #(
   parameter int NUM_SPRITES = 8
) (
   input  logic             req_valid,
   input  logic [1:0]       req_type,
   input  logic [2:0]       req_sprite_index,
   input  logic [14:0]      req_rand_speed,
   input  logic             req_keep_x_sign,
   input  logic             req_keep_y_sign,
   input  logic [14:0]      req_rand_x,
   input  logic [14:0]      req_rand_y,
   input  logic             q_full,
   output logic             req_stall,
   output logic             push,
   output bsm_pkg::cmd_type push_cmd
);

   logic useful;

   always_comb begin
      push_cmd.sprite     = req_sprite_index;
      push_cmd.rand_speed = req_rand_speed;
      push_cmd.keep_x     = req_keep_x_sign;
      push_cmd.keep_y     = req_keep_y_sign;
      push_cmd.rand_x     = req_rand_x;
      push_cmd.rand_y     = req_rand_y;
      push_cmd.op         = bsm_pkg::OP_STEP;
      useful              = 1'b0;
      case (req_type)
         bsm_pkg::REQ_STEP: begin
            push_cmd.op = bsm_pkg::OP_STEP;
            useful      = int'(req_sprite_index) < NUM_SPRITES;
         end
         bsm_pkg::REQ_INVERT: begin
            push_cmd.op = bsm_pkg::OP_INVERT;
            useful      = 1'b1;
         end
         bsm_pkg::REQ_REVERSE: begin
            push_cmd.op = bsm_pkg::OP_REVERSE;
            useful      = 1'b1;
         end
         default: begin
            useful = 1'b0;
         end
      endcase
   end

   // unknown codes and steps for out-of-range sprites are taken and dropped here
   assign req_stall = q_full;
   assign push      = req_valid & ~q_full & useful;

endmodule

FILE: rtl/bsm_fifo.sv
module bsm_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bsm_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output bsm_pkg::cmd_type head
);

   bsm_pkg::cmd_type                 q_ff [bsm_pkg::QUEUE_DEPTH];
   logic [bsm_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [bsm_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [bsm_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign full  = count_ff == bsm_pkg::QCNT_W'(bsm_pkg::QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/bsm_back.sv
module bsm_back #(
   parameter int NUM_SPRITES = 8,
   localparam int IDX_W = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bsm_pkg::cfg_type        cfg,
   input  logic                    q_empty,
   input  bsm_pkg::cmd_type        head,
   output logic                    pop,
   output logic                    ram_wr_en,
   output logic [IDX_W-1:0]        ram_wr_addr,
   output bsm_pkg::rec_type        ram_wr_data,
   output logic [IDX_W-1:0]        ram_rd_addr,
   input  bsm_pkg::rec_type        ram_rd_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_out_sprite,
   output logic                    rsp_erase_valid,
   output logic signed [13:0]      rsp_erase_x,
   output logic signed [13:0]      rsp_erase_y,
   output logic                    rsp_erase_inverted,
   output logic signed [13:0]      rsp_draw_x,
   output logic signed [13:0]      rsp_draw_y,
   output logic                    rsp_draw_inverted
);

   bsm_pkg::state_type  state_ff, state_in;
   bsm_pkg::cmd_type    cur_ff, cur_in;
   bsm_pkg::rec_type    old_ff, old_in;
   logic [NUM_SPRITES-1:0] known_ff, known_in;
   logic                invert_ff, invert_in;
   logic                reverse_ff, reverse_in;
   logic                erase_ff, erase_in;
   logic [15:0]         t_ff, t_in;
   logic [15:0]         r_ff, r_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic [31:0]         nx_ff, nx_in;
   logic [31:0]         ny_ff, ny_in;
   logic [20:0]         vx_ff, vx_in;
   logic [20:0]         vy_ff, vy_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          out_sprite_ff, out_sprite_in;
   logic                erase_valid_ff, erase_valid_in;
   logic [13:0]         erase_x_ff, erase_x_in;
   logic [13:0]         erase_y_ff, erase_y_in;
   logic                erase_inv_ff, erase_inv_in;
   logic [13:0]         draw_x_ff, draw_x_in;
   logic [13:0]         draw_y_ff, draw_y_in;
   logic                draw_inv_ff, draw_inv_in;

   logic [IDX_W-1:0]    cur_addr;
   logic [15:0]         ax;
   logic [31:0]         ax_sq;
   logic [15:0]         cand;
   logic [31:0]         cand_sq;
   logic [19:0]         mag_x;
   logic [19:0]         mag_y;
   logic                neg_x;
   logic                neg_y;
   logic                place_y;
   logic [14:0]         place_rand;
   logic [11:0]         place_base;
   logic [11:0]         place_hi;
   logic signed [13:0]  place_span;
   logic signed [29:0]  place_prod;
   logic [31:0]         place_sum;
   logic [31:0]         eff_x;
   logic [31:0]         eff_y;
   logic signed [16:0]  xl;
   logic signed [16:0]  xr;
   logic signed [16:0]  yb;
   logic signed [16:0]  yt;
   logic signed [16:0]  ipx;
   logic signed [16:0]  ipy;
   logic                out_free;

   function automatic logic [31:0] eff_vel(input logic [20:0] v, input logic rev);
      logic [31:0] sv;
      sv = {{11{v[20]}}, v};
      return rev ? 32'd0 - sv : sv;
   endfunction

   assign cur_addr = IDX_W'(cur_ff.sprite);
   assign ax       = {cur_ff.rand_speed, 1'b0};
   assign ax_sq    = ax * ax;
   assign cand     = r_ff | (16'd1 << cnt_ff);
   assign cand_sq  = cand * cand;
   assign mag_x    = ax * cfg.speed;
   assign mag_y    = r_ff * cfg.speed;
   assign neg_x    = ~cur_ff.keep_x ^ reverse_ff;
   assign neg_y    = ~cur_ff.keep_y ^ reverse_ff;

   // start offset: rand * usable span * 2, signed, on top of the low edge
   assign place_y    = state_ff == bsm_pkg::ST_PLACE_Y;
   assign place_rand = place_y ? cur_ff.rand_y : cur_ff.rand_x;
   assign place_base = place_y ? cfg.y_bottom : cfg.x_left;
   assign place_hi   = place_y ? cfg.y_top : cfg.x_right;
   assign place_span = 14'(place_hi) - 14'(bsm_pkg::SPRITE_SIZE) - 14'(place_base);
   assign place_prod = $signed({1'b0, place_rand}) * place_span;
   assign place_sum  = {4'd0, place_base, 16'd0} + {place_prod[29], place_prod, 1'b0};

   assign eff_x = eff_vel(ram_rd_data.vel_x, reverse_ff);
   assign eff_y = eff_vel(ram_rd_data.vel_y, reverse_ff);

   assign xl  = $signed({5'd0, cfg.x_left});
   assign xr  = $signed({5'd0, cfg.x_right} - 17'(bsm_pkg::SPRITE_SIZE));
   assign yb  = $signed({5'd0, cfg.y_bottom});
   assign yt  = $signed({5'd0, cfg.y_top} - 17'(bsm_pkg::SPRITE_SIZE));
   assign ipx = $signed({nx_ff[31], nx_ff[31:16]});
   assign ipy = $signed({ny_ff[31], ny_ff[31:16]});

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      old_in         = old_ff;
      known_in       = known_ff;
      invert_in      = invert_ff;
      reverse_in     = reverse_ff;
      erase_in       = erase_ff;
      t_in           = t_ff;
      r_in           = r_ff;
      cnt_in         = cnt_ff;
      nx_in          = nx_ff;
      ny_in          = ny_ff;
      vx_in          = vx_ff;
      vy_in          = vy_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      out_sprite_in  = out_sprite_ff;
      erase_valid_in = erase_valid_ff;
      erase_x_in     = erase_x_ff;
      erase_y_in     = erase_y_ff;
      erase_inv_in   = erase_inv_ff;
      draw_x_in      = draw_x_ff;
      draw_y_in      = draw_y_ff;
      draw_inv_in    = draw_inv_ff;
      pop            = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = cur_addr;
      ram_rd_addr    = IDX_W'(head.sprite);
      ram_wr_data.pos_x     = nx_ff;
      ram_wr_data.pos_y     = ny_ff;
      ram_wr_data.vel_x     = vx_ff;
      ram_wr_data.vel_y     = vy_ff;
      ram_wr_data.drawn_inv = invert_ff;

      case (state_ff)
         bsm_pkg::ST_IDLE: begin
            if (!q_empty) begin
               pop    = 1'b1;
               cur_in = head;
               case (head.op)
                  bsm_pkg::OP_INVERT:  invert_in  = ~invert_ff;
                  bsm_pkg::OP_REVERSE: reverse_in = ~reverse_ff;
                  bsm_pkg::OP_STEP:    state_in   = bsm_pkg::ST_FETCH;
                  default: ;
               endcase
            end
         end
         bsm_pkg::ST_FETCH: begin
            old_in = ram_rd_data;
            if (known_ff[cur_addr]) begin
               erase_in = 1'b1;
               nx_in    = ram_rd_data.pos_x + eff_x;
               ny_in    = ram_rd_data.pos_y + eff_y;
               vx_in    = ram_rd_data.vel_x;
               vy_in    = ram_rd_data.vel_y;
               state_in = bsm_pkg::ST_BOUNCE;
            end else begin
               erase_in = 1'b0;
               t_in     = ~ax_sq[31:16];
               r_in     = '0;
               cnt_in   = 4'd15;
               state_in = bsm_pkg::ST_ROOT;
            end
         end
         bsm_pkg::ST_ROOT: begin
            // one result bit a cycle, most significant first
            if (cand_sq[31:16] <= t_ff) begin
               r_in = cand;
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = bsm_pkg::ST_SCALE;
            end
         end
         bsm_pkg::ST_SCALE: begin
            vx_in    = neg_x ? 21'd0 - {1'b0, mag_x} : {1'b0, mag_x};
            vy_in    = neg_y ? 21'd0 - {1'b0, mag_y} : {1'b0, mag_y};
            state_in = bsm_pkg::ST_PLACE_X;
         end
         bsm_pkg::ST_PLACE_X: begin
            nx_in    = place_sum;
            state_in = bsm_pkg::ST_PLACE_Y;
         end
         bsm_pkg::ST_PLACE_Y: begin
            ny_in    = place_sum;
            state_in = bsm_pkg::ST_DONE;
         end
         bsm_pkg::ST_BOUNCE: begin
            // reflection mirrors the position about the edge
            if (ipx < xl) begin
               nx_in = {xl[14:0], 17'd0} - nx_ff;
               vx_in = 21'd0 - vx_ff;
            end else if (ipx > xr) begin
               nx_in = {xr[14:0], 17'd0} - nx_ff;
               vx_in = 21'd0 - vx_ff;
            end
            if (ipy < yb) begin
               ny_in = {yb[14:0], 17'd0} - ny_ff;
               vy_in = 21'd0 - vy_ff;
            end else if (ipy >= yt) begin
               ny_in = {yt[14:0], 17'd0} - ny_ff;
               vy_in = 21'd0 - vy_ff;
            end
            state_in = bsm_pkg::ST_DONE;
         end
         bsm_pkg::ST_DONE: begin
            if (out_free) begin
               ram_wr_en          = 1'b1;
               known_in[cur_addr] = 1'b1;
               rsp_valid_in       = 1'b1;
               out_sprite_in      = cur_ff.sprite;
               erase_valid_in     = erase_ff;
               erase_x_in         = erase_ff ? old_ff.pos_x[29:16] : '0;
               erase_y_in         = erase_ff ? old_ff.pos_y[29:16] : '0;
               erase_inv_in       = erase_ff & old_ff.drawn_inv;
               draw_x_in          = nx_ff[29:16];
               draw_y_in          = ny_ff[29:16];
               draw_inv_in        = invert_ff;
               state_in           = bsm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bsm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsm_pkg::ST_IDLE;
         known_ff     <= '0;
         invert_ff    <= 1'b0;
         reverse_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         known_ff     <= known_in;
         invert_ff    <= invert_in;
         reverse_ff   <= reverse_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      old_ff         <= old_in;
      erase_ff       <= erase_in;
      t_ff           <= t_in;
      r_ff           <= r_in;
      cnt_ff         <= cnt_in;
      nx_ff          <= nx_in;
      ny_ff          <= ny_in;
      vx_ff          <= vx_in;
      vy_ff          <= vy_in;
      out_sprite_ff  <= out_sprite_in;
      erase_valid_ff <= erase_valid_in;
      erase_x_ff     <= erase_x_in;
      erase_y_ff     <= erase_y_in;
      erase_inv_ff   <= erase_inv_in;
      draw_x_ff      <= draw_x_in;
      draw_y_ff      <= draw_y_in;
      draw_inv_ff    <= draw_inv_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_sprite     = out_sprite_ff;
   assign rsp_erase_valid    = erase_valid_ff;
   assign rsp_erase_x        = $signed(erase_x_ff);
   assign rsp_erase_y        = $signed(erase_y_ff);
   assign rsp_erase_inverted = erase_inv_ff;
   assign rsp_draw_x         = $signed(draw_x_ff);
   assign rsp_draw_y         = $signed(draw_y_ff);
   assign rsp_draw_inverted  = draw_inv_ff;

endmodule

FILE: verif/tb_bouncing_sprite_motion.sv
`timescale 1ns / 1ps

module tb_bouncing_sprite_motion;

   localparam int         N_SPRITES  = 8;
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int         SETTLE     = 40;
   localparam int         LONG_HOLD  = 300;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  sprite;
      logic [14:0] rand_speed;
      logic        keep_x;
      logic        keep_y;
      logic [14:0] rand_x;
      logic [14:0] rand_y;
   } move_req_type;

   typedef struct packed {
      logic [2:0]  sprite;
      logic        erase_valid;
      logic [13:0] erase_x;
      logic [13:0] erase_y;
      logic        erase_inv;
      logic [13:0] draw_x;
      logic [13:0] draw_y;
      logic        draw_inv;
   } move_beat_type;

   typedef struct packed {
      move_req_type  req;
      logic          typed;
      move_beat_type want;
   } probe_type;

   typedef struct packed {
      logic [11:0] x_left, x_right, y_bottom, y_top;
      logic [3:0]  speed;
      logic [3:0]  reach;
      logic [11:0] count;
   } phase_type;

   localparam move_beat_type NO_BEAT   = '0;
   localparam move_beat_type S0_ORIGIN = '{3'd0, 1'b0, 14'd0, 14'd0, 1'b0, 14'd0, 14'd0, 1'b0};
   // full random offsets on the reset screen land one pixel short of the far edges
   localparam move_beat_type S1_FAR    =
      '{3'd1, 1'b0, 14'd0, 14'd0, 1'b0, 14'd607, 14'd447, 1'b0};

   localparam probe_type PROBES [24] = '{
      '{'{bsm_pkg::REQ_STEP, 3'd0, 15'h0000, 1'b1, 1'b1, 15'h0000, 15'h0000}, 1'b1, S0_ORIGIN},
      '{'{bsm_pkg::REQ_STEP, 3'd1, 15'h7fff, 1'b0, 1'b0, 15'h7fff, 15'h7fff}, 1'b1, S1_FAR},
      '{'{bsm_pkg::REQ_STEP, 3'd2, 15'h4000, 1'b1, 1'b0, 15'h4000, 15'h1234}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_STEP, 3'd3, 15'h5a5a, 1'b0, 1'b1, 15'h2aaa, 15'h5555}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_INVERT, 3'd0, 15'h0000, 1'b0, 1'b0, 15'h0000, 15'h0000}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_STEP, 3'd0, 15'h7fff, 1'b0, 1'b0, 15'h7fff, 15'h7fff}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_STEP, 3'd1, 15'h0000, 1'b1, 1'b1, 15'h0000, 15'h0000}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_REVERSE, 3'd0, 15'h0000, 1'b0, 1'b0, 15'h0000, 15'h0000}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_STEP, 3'd1, 15'h1111, 1'b1, 1'b0, 15'h2222, 15'h3333}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_STEP, 3'd2, 15'h0000, 1'b0, 1'b1, 15'h0000, 15'h0000}, 1'b0, NO_BEAT},
      '{'{REQ_UNUSED, 3'd0, 15'h7fff, 1'b1, 1'b1, 15'h7fff, 15'h7fff}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_STEP, 3'd3, 15'h0000, 1'b0, 1'b0, 15'h0000, 15'h0000}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_INVERT, 3'd7, 15'h7fff, 1'b1, 1'b1, 15'h7fff, 15'h7fff}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_REVERSE, 3'd7, 15'h7fff, 1'b1, 1'b1, 15'h7fff, 15'h7fff}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_STEP, 3'd0, 15'h0000, 1'b0, 1'b0, 15'h0000, 15'h0000}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_STEP, 3'd2, 15'h0000, 1'b0, 1'b0, 15'h0000, 15'h0000}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_STEP, 3'd1, 15'h0000, 1'b0, 1'b0, 15'h0000, 15'h0000}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_STEP, 3'd3, 15'h0000, 1'b0, 1'b0, 15'h0000, 15'h0000}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_REVERSE, 3'd0, 15'h0000, 1'b0, 1'b0, 15'h0000, 15'h0000}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_STEP, 3'd0, 15'h0000, 1'b0, 1'b0, 15'h0000, 15'h0000}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_STEP, 3'd1, 15'h0000, 1'b0, 1'b0, 15'h0000, 15'h0000}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_INVERT, 3'd0, 15'h0000, 1'b0, 1'b0, 15'h0000, 15'h0000}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_STEP, 3'd2, 15'h0000, 1'b0, 1'b0, 15'h0000, 15'h0000}, 1'b0, NO_BEAT},
      '{'{bsm_pkg::REQ_STEP, 3'd3, 15'h0000, 1'b0, 1'b0, 15'h0000, 15'h0000}, 1'b0, NO_BEAT}
   };

   // each phase but the last lets one more sprite into play, so each of those sprites starts on its own screen
   localparam phase_type PHASES [5] = '{
      '{12'd0,    12'd4095, 12'd0,    12'd4095, 4'd15, 4'd5, 12'd350},
      '{12'd100,  12'd700,  12'd50,   12'd500,  4'd0,  4'd6, 12'd350},
      '{12'd4095, 12'd0,    12'd4095, 12'd0,    4'd1,  4'd7, 12'd350},
      '{12'd37,   12'd300,  12'd20,   12'd250,  4'd7,  4'd8, 12'd350},
      '{12'd0,    12'd0,    12'd0,    12'd0,    4'd15, 4'd8, 12'd330}
   };

   logic               clock              = 1'b0;
   logic               reset              = 1'b1;
   logic               req_valid          = 1'b0;
   logic               req_stall;
   logic [1:0]         req_type           = bsm_pkg::REQ_STEP;
   logic [2:0]         req_sprite_index   = '0;
   logic [14:0]        req_rand_speed     = '0;
   logic               req_keep_x_sign    = 1'b0;
   logic               req_keep_y_sign    = 1'b0;
   logic [14:0]        req_rand_x         = '0;
   logic [14:0]        req_rand_y         = '0;
   logic               rsp_valid;
   logic               rsp_stall          = 1'b0;
   logic [2:0]         rsp_out_sprite;
   logic               rsp_erase_valid;
   logic signed [13:0] rsp_erase_x;
   logic signed [13:0] rsp_erase_y;
   logic               rsp_erase_inverted;
   logic signed [13:0] rsp_draw_x;
   logic signed [13:0] rsp_draw_y;
   logic               rsp_draw_inverted;
   logic               csr_valid          = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index          = bsm_pkg::CSR_X_LEFT;
   logic [11:0]        csr_wdata          = '0;

   // sprite table as the block should hold it
   logic [31:0] pos_x_m [N_SPRITES];
   logic [31:0] pos_y_m [N_SPRITES];
   logic [20:0] vel_x_m [N_SPRITES];
   logic [20:0] vel_y_m [N_SPRITES];
   bit          known_m [N_SPRITES];
   bit          drawn_inv_m [N_SPRITES];
   bit          invert_m;
   bit          reverse_m;
   bsm_pkg::cfg_type cfg_m = '{x_left: 12'd0, x_right: 12'd640, y_bottom: 12'd0,
                               y_top: 12'd480, speed: 4'd3};

   move_beat_type moves_due [$];
   move_beat_type due;
   int          n_bad, n_sent, n_moves, n_starts, n_bounces;
   int          hold_asked, hold_served, rsp_wait;
   bit          quiet;

   always #1 clock = ~clock;

   bouncing_sprite_motion #(
      .NUM_SPRITES(N_SPRITES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_sprite_index(req_sprite_index),
      .req_rand_speed(req_rand_speed),
      .req_keep_x_sign(req_keep_x_sign),
      .req_keep_y_sign(req_keep_y_sign),
      .req_rand_x(req_rand_x),
      .req_rand_y(req_rand_y),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_sprite(rsp_out_sprite),
      .rsp_erase_valid(rsp_erase_valid),
      .rsp_erase_x(rsp_erase_x),
      .rsp_erase_y(rsp_erase_y),
      .rsp_erase_inverted(rsp_erase_inverted),
      .rsp_draw_x(rsp_draw_x),
      .rsp_draw_y(rsp_draw_y),
      .rsp_draw_inverted(rsp_draw_inverted),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   function automatic int pixel(logic [31:0] p);
      return int'($signed(p[31:16]));
   endfunction

   // stored velocities are read negated while the reverse flag is set
   function automatic logic [31:0] live_vel(logic [20:0] v);
      int s;
      s = int'($signed(v));
      if (reverse_m) s = -s;
      return 32'(s);
   endfunction

   function automatic logic [20:0] stored_vel(int v);
      if (reverse_m) v = -v;
      return 21'(v);
   endfunction

   function automatic logic [31:0] mirror_at(int rim, logic [31:0] p);
      return 32'(rim * 131072) - p;
   endfunction

   function automatic logic [31:0] root16(logic [31:0] t);
      logic [31:0] r, b;
      r = '0;
      for (b = 32'h8000; b != 0; b = b >> 1) begin
         r = r ^ b;
         if (((r * r) >> 16) > t) r = r ^ b;
      end
      return r;
   endfunction

   function automatic bit predict_move(move_req_type q, output move_beat_type b);
      int          xl, xr, yb, yt, vx, vy, i;
      logic [31:0] ax, ay, nx, ny;
      longint      offx, offy;
      b  = '0;
      xl = int'(cfg_m.x_left);
      xr = int'(cfg_m.x_right) - bsm_pkg::SPRITE_SIZE;
      yb = int'(cfg_m.y_bottom);
      yt = int'(cfg_m.y_top) - bsm_pkg::SPRITE_SIZE;
      i  = int'(q.sprite);
      case (q.kind)
         bsm_pkg::REQ_INVERT: begin
            invert_m = ~invert_m;
            return 1'b0;
         end
         bsm_pkg::REQ_REVERSE: begin
            reverse_m = ~reverse_m;
            return 1'b0;
         end
         bsm_pkg::REQ_STEP: ;
         default: return 1'b0;
      endcase
      b.sprite = q.sprite;
      if (!known_m[i]) begin
         ax = 32'(q.rand_speed) << 1;
         ay = root16(32'd65535 - ((ax * ax) >> 16));
         vx = q.keep_x ? int'(ax) : -int'(ax);
         vy = q.keep_y ? int'(ay) : -int'(ay);
         vel_x_m[i] = stored_vel(vx * int'(cfg_m.speed));
         vel_y_m[i] = stored_vel(vy * int'(cfg_m.speed));
         // span may be negative when the edges sit too close
         offx = longint'(q.rand_x) * longint'(xr - xl) * 2;
         offy = longint'(q.rand_y) * longint'(yt - yb) * 2;
         nx = (32'(cfg_m.x_left) << 16) + 32'(offx);
         ny = (32'(cfg_m.y_bottom) << 16) + 32'(offy);
         n_starts++;
      end else begin
         nx = pos_x_m[i] + live_vel(vel_x_m[i]);
         ny = pos_y_m[i] + live_vel(vel_y_m[i]);
         if (pixel(nx) < xl) begin
            nx = mirror_at(xl, nx);
            vel_x_m[i] = -vel_x_m[i];
            n_bounces++;
         end else if (pixel(nx) > xr) begin
            nx = mirror_at(xr, nx);
            vel_x_m[i] = -vel_x_m[i];
            n_bounces++;
         end
         if (pixel(ny) < yb) begin
            ny = mirror_at(yb, ny);
            vel_y_m[i] = -vel_y_m[i];
            n_bounces++;
         end else if (pixel(ny) >= yt) begin
            ny = mirror_at(yt, ny);
            vel_y_m[i] = -vel_y_m[i];
            n_bounces++;
         end
         b.erase_valid = 1'b1;
         b.erase_x     = pos_x_m[i][29:16];
         b.erase_y     = pos_y_m[i][29:16];
         b.erase_inv   = drawn_inv_m[i];
      end
      b.draw_x       = nx[29:16];
      b.draw_y       = ny[29:16];
      b.draw_inv     = invert_m;
      pos_x_m[i]     = nx;
      pos_y_m[i]     = ny;
      drawn_inv_m[i] = invert_m;
      known_m[i]     = 1'b1;
      return 1'b1;
   endfunction

   function automatic logic [14:0] pick15();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return 15'($urandom_range(0, 32767));
      endcase
   endfunction

   function automatic move_req_type random_req(int reach);
      move_req_type q;
      int           r;
      r = $urandom_range(0, 99);
      if (r < 80)      q.kind = bsm_pkg::REQ_STEP;
      else if (r < 88) q.kind = bsm_pkg::REQ_INVERT;
      else if (r < 96) q.kind = bsm_pkg::REQ_REVERSE;
      else             q.kind = REQ_UNUSED;
      q.sprite     = 3'($urandom_range(0, reach - 1));
      q.rand_speed = pick15();
      q.keep_x     = 1'($urandom_range(0, 1));
      q.keep_y     = 1'($urandom_range(0, 1));
      q.rand_x     = pick15();
      q.rand_y     = pick15();
      return q;
   endfunction

   task automatic check_field(string tag, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", tag, want, got);
         n_bad++;
      end
   endtask

   // called at a rising edge; leaves valid high so a back-to-back beat needs no toggle
   task automatic offer(move_req_type q, bit calm, bit typed, move_beat_type want);
      int            gap;
      move_beat_type beat;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= q.kind;
      req_sprite_index <= q.sprite;
      req_rand_speed   <= q.rand_speed;
      req_keep_x_sign  <= q.keep_x;
      req_keep_y_sign  <= q.keep_y;
      req_rand_x       <= q.rand_x;
      req_rand_y       <= q.rand_y;
      do @(posedge clock); while (req_stall);
      if (predict_move(q, beat)) moves_due.push_back(typed ? want : beat);
      if (q.kind != REQ_UNUSED) n_sent++;
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (moves_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [11:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         bsm_pkg::CSR_X_LEFT:   cfg_m.x_left   = val;
         bsm_pkg::CSR_X_RIGHT:  cfg_m.x_right  = val;
         bsm_pkg::CSR_Y_BOTTOM: cfg_m.y_bottom = val;
         bsm_pkg::CSR_Y_TOP:    cfg_m.y_top    = val;
         bsm_pkg::CSR_SPEED:    cfg_m.speed    = val[3:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (moves_due.size() == 0) begin
            $error("move beat for sprite %0d with nothing expected", rsp_out_sprite);
            n_bad++;
         end else begin
            due = moves_due.pop_front();
            check_field("out_sprite", due.sprite, rsp_out_sprite);
            check_field("erase_valid", due.erase_valid, rsp_erase_valid);
            check_field("erase_x", $signed(due.erase_x), rsp_erase_x);
            check_field("erase_y", $signed(due.erase_y), rsp_erase_y);
            check_field("erase_inverted", due.erase_inv, rsp_erase_inverted);
            check_field("draw_x", $signed(due.draw_x), rsp_draw_x);
            check_field("draw_y", $signed(due.draw_y), rsp_draw_y);
            check_field("draw_inverted", due.draw_inv, rsp_draw_inverted);
            n_moves++;
         end
         rsp_wait = quiet ? 0 : $urandom_range(0, 13);
      end
      if (hold_served != hold_asked) begin
         hold_served++;
         rsp_wait = LONG_HOLD;
      end
      rsp_stall <= (rsp_wait != 0);
      if (rsp_wait != 0) rsp_wait--;
   end

   initial begin
      phase_type ph;
      bit        calm;
      int        p, k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (PROBES[r]) offer(PROBES[r].req, 1'b0, PROBES[r].typed, PROBES[r].want);
      for (p = 0; p < 5; p++) begin
         ph = PHASES[p];
         quiesce();
         write_reg(bsm_pkg::CSR_X_LEFT, ph.x_left);
         write_reg(bsm_pkg::CSR_X_RIGHT, ph.x_right);
         write_reg(bsm_pkg::CSR_Y_BOTTOM, ph.y_bottom);
         write_reg(bsm_pkg::CSR_Y_TOP, ph.y_top);
         write_reg(bsm_pkg::CSR_SPEED, {8'd0, ph.speed});
         csr_valid <= 1'b0;
         for (k = 0; k < int'(ph.count); k++) begin
            calm = (k % 150) < 30;
            quiet <= calm;
            // long output hold while requests keep coming: the queue fills and stalls
            if (p == 0 && k == 100) hold_asked <= hold_asked + 1;
            if (p == 1 && k == 200) quiesce();
            offer(random_req(int'(ph.reach)), calm, 1'b0, NO_BEAT);
         end
      end
      quiesce();
      $display("%0d requests over 6 screen settings gave %0d checked moves,", n_sent, n_moves);
      $display("with %0d sprite starts and %0d edge reflections.", n_starts, n_bounces);
      if (n_bad == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
